// ===== src/first_fit_block_allocator_assert.svh =====
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define FFBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned MaxBlocksDef = 64;
  localparam int unsigned AddrBitsDef  = 16;
  localparam int unsigned CfgIdxW      = 1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MERGE = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        is_free;
    logic [15:0] start;
    logic [15:0] bytes;
  } ffba_entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture request beat
    logic step;    // evaluate the entry just read
    logic finish;  // form the result and load the output register
  } ffba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan;      // request needs a table walk
    logic stop;      // walk ends with this entry
    logic out_busy;  // output register full and stalled
  } ffba_stat_t;

endpackage

// ===== src/ffba_ctrl.sv =====
// Sequencer of the first-fit block allocator.
module ffba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffba_pkg::ffba_stat_t stat_i,
  output ffba_pkg::ffba_cmd_t  cmd_o
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = stat_i.scan ? S_READ : S_FIN;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.step = 1'b1;
        state_d = stat_i.stop ? S_FIN : S_READ;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/ffba_dpath.sv =====
// Block table, heap registers and result register of the allocator.
module ffba_dpath #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::MaxBlocksDef,
  parameter int unsigned ADDR_BITS  = ffba_pkg::AddrBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [ffba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic [1:0]                   opcode_i,
  input  logic [15:0]                  req_size_i,
  input  logic [15:0]                  addr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ffba_pkg::status_e            status_o,
  output logic [15:0]                  addr_out_o,
  output logic [6:0]                   blocks_used_o,
  input  ffba_pkg::ffba_cmd_t          cmd_i,
  output ffba_pkg::ffba_stat_t         stat_o
);
  import ffba_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);
  localparam logic [32:0] AddrMask = (33'd1 << ADDR_BITS) - 33'd1;

  ffba_entry_t mem [MAX_BLOCKS];
  ffba_entry_t rdata_q;

  logic [7:0]    hdr_q;
  logic [15:0]   lim_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   top_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] w_q;
  logic          pv_q, found_q, out_valid_q;
  opcode_e       op_q;
  logic [15:0]   size_q, addr_q, found_addr_q;
  ffba_entry_t   prev_q;

  // write port
  logic          we;
  logic [IW-1:0] waddr;
  ffba_entry_t   wdata;

  logic [CW:0]   idx_nx;
  logic          hit, merge_join;
  logic [16:0]   last_end;
  logic [15:0]   join_bytes;
  logic [CW-1:0] w_m1;
  logic [16:0]   grow_base;
  logic [17:0]   grow_end;
  logic          grow_ok;
  status_e       res_status;
  logic [15:0]   res_addr;
  logic [31:0]   cnt_ext;

  assign idx_nx = (CW + 1)'(idx_q) + 1'b1;
  assign w_m1   = w_q - 1'b1;

  always_comb begin
    hit = 1'b0;
    case (op_q)
      OP_ALLOC: hit = rdata_q.is_free && (rdata_q.bytes >= size_q);
      OP_FREE:  hit = (rdata_q.start == addr_q);
      default:  hit = 1'b0;
    endcase
  end

  assign merge_join = pv_q && prev_q.is_free && rdata_q.is_free;
  assign last_end   = {1'b0, rdata_q.start} + {1'b0, rdata_q.bytes};
  assign join_bytes = (last_end >= {1'b0, prev_q.start}) ?
                      16'(last_end - {1'b0, prev_q.start}) : 16'd0;

  assign grow_base = {1'b0, top_q} + {9'd0, hdr_q};
  assign grow_end  = {1'b0, grow_base} + {2'b00, size_q};
  assign grow_ok   = (cnt_q != MaxCnt) && (grow_end <= {2'b00, lim_q}) &&
                     (33'(grow_end) <= AddrMask);

  always_comb begin
    stat_o.scan = (cnt_q != '0) &&
                  ((opcode_e'(opcode_i) == OP_ALLOC && req_size_i != 16'd0) ||
                   (opcode_e'(opcode_i) == OP_FREE  && addr_i != 16'd0) ||
                   (opcode_e'(opcode_i) == OP_MERGE));
    stat_o.stop = ((op_q == OP_ALLOC || op_q == OP_FREE) && hit) ||
                  (idx_nx >= {1'b0, cnt_q});
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

  // table writes: hit mark, merge compaction, or append
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rdata_q;
    if (cmd_i.step) begin
      case (op_q)
        OP_ALLOC: begin
          we = hit;
          wdata.is_free = 1'b0;
        end
        OP_FREE: begin
          we = hit;
          wdata.is_free = 1'b1;
        end
        OP_MERGE: begin
          we = 1'b1;
          if (merge_join) begin
            waddr = w_m1[IW-1:0];
            wdata = '{is_free: 1'b1, start: prev_q.start, bytes: join_bytes};
          end else begin
            waddr = w_q[IW-1:0];
          end
        end
        default: we = 1'b0;
      endcase
    end else if (cmd_i.finish && op_q == OP_ALLOC && size_q != 16'd0 &&
                 !found_q && grow_ok) begin
      we    = 1'b1;
      waddr = cnt_q[IW-1:0];
      wdata = '{is_free: 1'b0, start: grow_base[15:0], bytes: size_q};
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_addr   = 16'd0;
    case (op_q)
      OP_ALLOC: begin
        if (size_q == 16'd0) begin
          res_status = ST_NULL;
        end else if (found_q) begin
          res_addr = found_addr_q;
        end else if (grow_ok) begin
          res_addr = grow_base[15:0];
        end else begin
          res_status = ST_NOSPACE;
        end
      end
      OP_FREE: begin
        if (addr_q == 16'd0) res_status = ST_NULL;
        else if (!found_q) res_status = ST_NOTFOUND;
      end
      default: res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= 8'd24;
      lim_q       <= 16'hFFFF;
      cnt_q       <= '0;
      top_q       <= 16'd0;
      idx_q       <= '0;
      w_q         <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_NOP;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HEADER: hdr_q <= cfg_data_i[7:0];
          CFG_LIMIT:  lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.start) begin
        op_q    <= opcode_e'(opcode_i);
        idx_q   <= '0;
        w_q     <= '0;
        pv_q    <= 1'b0;
        found_q <= 1'b0;
      end
      if (cmd_i.step) begin
        idx_q <= idx_nx[IW-1:0];
        if ((op_q == OP_ALLOC || op_q == OP_FREE) && hit) found_q <= 1'b1;
        if (op_q == OP_MERGE && !merge_join) begin
          w_q  <= w_q + 1'b1;
          pv_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (op_q == OP_MERGE) cnt_q <= w_q;
        if (op_q == OP_ALLOC && size_q != 16'd0 && !found_q && grow_ok) begin
          cnt_q <= cnt_q + 1'b1;
          top_q <= grow_end[15:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q <= req_size_i;
      addr_q <= addr_i;
    end
    if (cmd_i.step) begin
      if (op_q == OP_ALLOC && hit) found_addr_q <= rdata_q.start;
      if (op_q == OP_MERGE) begin
        prev_q <= merge_join ? wdata : rdata_q;
      end
    end
    if (cmd_i.finish) begin
      status_o   <= res_status;
      addr_out_o <= res_addr;
    end
  end

  // result count follows the table count once the beat is formed
  logic [CW-1:0] used_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (op_q == OP_MERGE) used_q <= w_q;
      else if (op_q == OP_ALLOC && size_q != 16'd0 && !found_q && grow_ok)
        used_q <= cnt_q + 1'b1;
      else used_q <= cnt_q;
    end
  end

  assign cnt_ext       = 32'(used_q);
  assign blocks_used_o = cnt_ext[6:0];
  assign out_valid_o   = out_valid_q;

`include "first_fit_block_allocator_assert.svh"
  `FFBA_ASSERT(a_cnt_bound, cnt_q <= MaxCnt, "entry count above table depth")
  `FFBA_ASSERT(a_step_in_range, !cmd_i.step || (idx_nx <= {1'b0, cnt_q}), "walk past count")
  `FFBA_ASSERT_NEXT(a_cnt_only_at_finish, !cmd_i.finish, $stable(cnt_q), "count moved mid-walk")
  `FFBA_ASSERT_NEXT(a_finish_sets_valid, cmd_i.finish, out_valid_q, "result beat lost")

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator: top level joining sequencer and datapath.
//
// Keeps an address-ordered table of up to MAX_BLOCKS heap blocks in a
// single-port-write memory with a registered read. Each request beat walks
// the table entry by entry, reading each entry and then evaluating it. An
// allocate or free stops at the first fit or match or at the table end, a
// merge visits every entry, and requests that need no walk go straight to
// the result. Merge compacts in the same pass, writing behind the read
// pointer. One request is in work at a time; a finished result sits in the
// output register while the next request beat is accepted. Configuration
// (header_bytes index 0, heap_limit index 1) is always ready and must only
// be written while idle.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::MaxBlocksDef,
  parameter int unsigned ADDR_BITS  = ffba_pkg::AddrBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffba_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [15:0]                  req_size_i,
  input  logic [15:0]                  addr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ffba_pkg::status_e            status_o,
  output logic [15:0]                  addr_out_o,
  output logic [6:0]                   blocks_used_o
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .req_size_i    (req_size_i),
    .addr_i        (addr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .addr_out_o    (addr_out_o),
    .blocks_used_o (blocks_used_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

// ===== dv/alloc_scoreboard.sv =====
// Scoreboard class: predicts allocator results and checks them in order.
`timescale 1ns / 1ps
class alloc_scoreboard;
  logic [15:0] blk_start [64];
  logic [15:0] blk_bytes [64];
  bit          blk_free [64];
  int unsigned n_entries;
  logic [16:0] top;
  logic [7:0]  hdr;
  logic [15:0] limit;
  logic [24:0] pending [$];
  int unsigned errors;

  function void init();
    n_entries = 0; top = 0; hdr = 8'd24; limit = 16'hFFFF; errors = 0;
  endfunction

  function void set_reg(ffba_pkg::cfg_idx_e idx, logic [15:0] d);
    if (idx == ffba_pkg::CFG_HEADER) hdr = d[7:0];
    else limit = d;
  endfunction

  // note an accepted request beat, queue its expected result
  function void note_request(logic [1:0] op, logic [15:0] sz, logic [15:0] a);
    ffba_pkg::status_e st;
    logic [15:0] grant;
    logic [17:0] fin;
    logic [16:0] last_end;
    int unsigned w;
    bit done;
    st = ffba_pkg::ST_OK; grant = 0; done = 0;
    case (op)
      ffba_pkg::OP_ALLOC: begin
        if (sz == 0) st = ffba_pkg::ST_NULL;
        else begin
          for (int i = 0; i < n_entries && !done; i++)
            if (blk_free[i] && blk_bytes[i] >= sz) begin
              blk_free[i] = 0; grant = blk_start[i]; done = 1;
            end
          if (!done) begin
            fin = top + hdr + sz;
            if (n_entries >= 64 || fin > limit || fin > 18'hFFFF) st = ffba_pkg::ST_NOSPACE;
            else begin
              blk_start[n_entries] = 16'(top + hdr);
              blk_bytes[n_entries] = sz;
              blk_free[n_entries] = 0;
              grant = 16'(top + hdr);
              n_entries++;
              top = 17'(fin);
            end
          end
        end
      end
      ffba_pkg::OP_FREE: begin
        if (a == 0) st = ffba_pkg::ST_NULL;
        else begin
          for (int i = 0; i < n_entries && !done; i++)
            if (blk_start[i] == a) begin
              blk_free[i] = 1; done = 1;
            end
          if (!done) st = ffba_pkg::ST_NOTFOUND;
        end
      end
      ffba_pkg::OP_MERGE: begin
        w = 0;
        for (int r = 0; r < n_entries; r++) begin
          if (w > 0 && blk_free[w-1] && blk_free[r]) begin
            last_end = blk_start[r] + blk_bytes[r];
            blk_bytes[w-1] = (last_end >= blk_start[w-1]) ?
                             16'(last_end - blk_start[w-1]) : 16'd0;
          end else begin
            blk_start[w] = blk_start[r]; blk_bytes[w] = blk_bytes[r];
            blk_free[w] = blk_free[r]; w++;
          end
        end
        n_entries = w;
      end
      default: ;
    endcase
    pending.push_back({st, grant, 7'(n_entries)});
  endfunction

  function void check_result(logic [1:0] st, logic [15:0] ao, logic [6:0] bu);
    logic [24:0] e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result st=%0d addr=%0d used=%0d", $time, st, ao, bu);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (st !== e[24:23]) begin
      $display("%0t: status exp %0d got %0d", $time, e[24:23], st); errors++;
    end
    if (ao !== e[22:7]) begin
      $display("%0t: addr_out exp %0d got %0d", $time, e[22:7], ao); errors++;
    end
    if (bu !== e[6:0]) begin
      $display("%0t: blocks_used exp %0d got %0d", $time, e[6:0], bu); errors++;
    end
  endfunction
endclass

// ===== dv/tb_top.sv =====
// Testbench top: drives the allocator with directed and random beats.
`timescale 1ns / 1ps
module tb_top;
  import ffba_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [15:0] req_size_i, addr_i;
  logic        out_valid_o, out_stall_i;
  status_e     status_o;
  logic [15:0] addr_out_o;
  logic [6:0]  blocks_used_o;

  alloc_scoreboard sb;
  logic [15:0] granted [$];  // payload addresses handed out, for realistic frees
  int unsigned stall_mode;

  first_fit_block_allocator DUT (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: stall pattern switches between none, sparse, heavy
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // sample results at the rising edge; harvest granted addresses
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (addr_out_o != 0 && granted.size() < 200) granted.push_back(addr_out_o);
      sb.check_result(status_o, addr_out_o, blocks_used_o);
    end
  end

  task automatic send_beat(logic [1:0] op, logic [15:0] sz, logic [15:0] a);
    in_valid_i = 1'b1; opcode_i = op; req_size_i = sz; addr_i = a;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, sz, a);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait for drain plus the worst-case walk before touching a register
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] d);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one random beat: mostly alloc/free of live addresses, some noise
  task automatic random_beat(int unsigned max_sz);
    int unsigned r;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    if (r < 45) send_beat(OP_ALLOC, 16'($urandom_range(0, max_sz)), 16'($urandom));
    else if (r < 80) begin
      if (granted.size() != 0 && $urandom_range(0, 4) != 0)
        a = granted[$urandom_range(0, granted.size() - 1)];
      else a = 16'($urandom);
      send_beat(OP_FREE, 16'($urandom), a);
    end else if (r < 92) send_beat(OP_MERGE, 16'($urandom), 16'($urandom));
    else if (r < 96) send_beat(OP_NOP, 16'($urandom), 16'($urandom));
    else send_beat(OP_ALLOC, 16'hFFFF - 16'($urandom_range(0, 3)), 16'($urandom));
  endtask

  initial begin
    int unsigned burst;
    sb = new();
    sb.init();
    stall_mode = 0;
    rst_ni = 1'b0; cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    in_valid_i = 0; opcode_i = 0; req_size_i = 0; addr_i = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero size, null free, unmatched free, double free, merge, nop
    send_beat(OP_ALLOC, 16'd0, 16'd0);
    send_beat(OP_ALLOC, 16'd100, 16'd0);
    send_beat(OP_ALLOC, 16'd50, 16'd0);
    send_beat(OP_ALLOC, 16'd1, 16'd0);
    send_beat(OP_FREE, 16'd0, 16'd0);
    send_beat(OP_FREE, 16'd0, 16'd7);
    send_beat(OP_FREE, 16'd0, 16'd24);
    send_beat(OP_FREE, 16'd0, 16'd24);
    send_beat(OP_FREE, 16'd0, 16'd148);
    send_beat(OP_ALLOC, 16'd60, 16'd0);     // first fit reuses the 100-byte block
    send_beat(OP_FREE, 16'd0, 16'd24);
    send_beat(OP_MERGE, 16'd0, 16'd0);
    send_beat(OP_NOP, 16'hFFFF, 16'hFFFF);
    send_beat(OP_ALLOC, 16'hFFFF, 16'hFFFF); // no space, address limit
    drain();

    // limit below heap top, then zero header, then maximum header with zero limit
    write_reg(CFG_LIMIT, 16'd10);
    send_beat(OP_ALLOC, 16'd500, 16'd0);
    drain();
    write_reg(CFG_HEADER, 16'd0);
    write_reg(CFG_LIMIT, 16'hFFFF);
    send_beat(OP_ALLOC, 16'd8, 16'd0);
    send_beat(OP_FREE, 16'd0, 16'd0);
    send_beat(OP_MERGE, 16'd0, 16'd0);
    drain();
    write_reg(CFG_HEADER, 16'd255);
    write_reg(CFG_LIMIT, 16'd0);
    send_beat(OP_ALLOC, 16'd1, 16'd0);
    drain();

    // random phases with different settings; small sizes (full range in phase 3) keep table busy
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_HEADER, 16'd24); write_reg(CFG_LIMIT, 16'hFFFF); end
        1: begin write_reg(CFG_HEADER, 16'd8); write_reg(CFG_LIMIT, 16'hC000); end
        2: begin write_reg(CFG_HEADER, 16'($urandom_range(0, 255)));
                 write_reg(CFG_LIMIT, 16'($urandom)); end
        3: begin write_reg(CFG_HEADER, 16'd0); write_reg(CFG_LIMIT, 16'hFFFF); end
        4: begin write_reg(CFG_HEADER, 16'd255); write_reg(CFG_LIMIT, 16'hFFFE); end
        default: begin write_reg(CFG_HEADER, 16'd16); write_reg(CFG_LIMIT, 16'hFFFF); end
      endcase
      for (int n = 0; n < 90;) begin
        stall_mode = $urandom_range(0, 2);
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          random_beat((ph == 3) ? 65535 : 400);
          n++;
        end
        repeat ($urandom_range(0, 20)) @(negedge clk_i);
      end
      drain();
    end

    stall_mode = 0;
    drain();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/ffba_pkg.sv
src/ffba_ctrl.sv
src/ffba_dpath.sv
src/first_fit_block_allocator.sv
dv/alloc_scoreboard.sv
dv/tb_top.sv
